FILE: rtl/iaw_pkg.sv
package iaw_pkg;

  // Build-time limits
  localparam int unsigned MAX_DIM      = 1024;
  localparam int unsigned MAX_CHANNELS = 1024;
  localparam int unsigned ROW_DILATION = 1;
  localparam int unsigned COL_DILATION = 1;

  // Field widths
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned CH_W      = 11;
  localparam int unsigned K_W       = 4;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ADDR_W    = 30;

  localparam int unsigned K_MAX      = 15;
  localparam int unsigned PAD_MAX    = 15;
  localparam int unsigned STRIDE_MAX = 15;
  localparam int unsigned FIELD_MAX  = 2047;

  localparam int unsigned DIM_LIMIT = (MAX_DIM < FIELD_MAX) ? MAX_DIM : FIELD_MAX;
  localparam int unsigned CH_LIMIT  = (MAX_CHANNELS < FIELD_MAX) ? MAX_CHANNELS : FIELD_MAX;

  localparam int unsigned PADDED_MAX = DIM_LIMIT + 2 * PAD_MAX;
  localparam int unsigned OUT_W      = $clog2(PADDED_MAX + 1);
  localparam int unsigned DIL_MAX    = (ROW_DILATION > COL_DILATION) ? ROW_DILATION : COL_DILATION;
  localparam int unsigned EXT_MAX    = DIL_MAX * (K_MAX - 1) + 1;
  localparam int unsigned EXT_W      = $clog2(EXT_MAX + 1);
  localparam int unsigned SZ_W       = (OUT_W > EXT_W) ? OUT_W : EXT_W;
  localparam int unsigned POS_MAX    = (PADDED_MAX - 1) * STRIDE_MAX + K_MAX * DIL_MAX;
  localparam int unsigned POS_W      = $clog2(POS_MAX + 1);
  localparam int unsigned HW_W       = 2 * DIM_W;
  localparam int unsigned DIV_CNT_W  = $clog2(OUT_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_HEIGHT  = 3'd0,
    CFG_IMAGE_WIDTH   = 3'd1,
    CFG_KERNEL_HEIGHT = 3'd2,
    CFG_KERNEL_WIDTH  = 3'd3,
    CFG_PAD_ROWS      = 3'd4,
    CFG_PAD_COLS      = 3'd5,
    CFG_STRIDE_ROWS   = 3'd6,
    CFG_STRIDE_COLS   = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_NEXT  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADDR
  } iaw_state_e;

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0] channel_count;
  } iaw_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic              is_pad;
    logic              last;
  } iaw_out_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic calc;
    logic advance;
  } iaw_cmd_t;

  typedef struct packed {
    logic div_last;
    logic walk_active;
  } iaw_status_t;

endpackage

FILE: rtl/im2col_address_walk_unit.sv
// Start transfer: accepted, then bit-serial output-size division over OUT_W quotient
//   bits runs while the input stalls; no result.
// Next transfer: the row/column stage registers load on acceptance, then the result
//   register loads (later while a stalled result holds it); the input stalls until
//   then, so a new next transfer is taken only after the previous one is done.
// Reset (async, active low): walk idle, counters cleared, configuration registers at their defaults.
module im2col_address_walk_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [iaw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [iaw_pkg::CFG_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  iaw_pkg::iaw_in_t              in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output iaw_pkg::iaw_out_t             out_data_o
);

  // The controller sequences start (divide) and next (row/column stage, then
  // address and counter advance). The datapath holds configuration, the walk
  // counters, the channel base and the result register. A next transfer with
  // no active walk is taken and dropped.
  iaw_pkg::iaw_cmd_t    cmd;
  iaw_pkg::iaw_status_t status;

  iaw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_data_i.req_type),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  iaw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/iaw_datapath.sv
module iaw_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [iaw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [iaw_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  iaw_pkg::iaw_in_t               in_data_i,
  input  iaw_pkg::iaw_cmd_t              cmd_i,
  output iaw_pkg::iaw_status_t           status_o,
  output iaw_pkg::iaw_out_t              out_data_o
);

  localparam int unsigned DIM_W     = iaw_pkg::DIM_W;
  localparam int unsigned CH_W      = iaw_pkg::CH_W;
  localparam int unsigned K_W       = iaw_pkg::K_W;
  localparam int unsigned OUT_W     = iaw_pkg::OUT_W;
  localparam int unsigned SZ_W      = iaw_pkg::SZ_W;
  localparam int unsigned POS_W     = iaw_pkg::POS_W;
  localparam int unsigned HW_W      = iaw_pkg::HW_W;
  localparam int unsigned ADDR_W    = iaw_pkg::ADDR_W;
  localparam int unsigned DIV_CNT_W = iaw_pkg::DIV_CNT_W;

  // Configuration registers
  logic [DIM_W-1:0] img_h_q, img_w_q;
  logic [K_W-1:0]   ker_h_q, ker_w_q, pad_r_q, pad_c_q, str_r_q, str_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q <= DIM_W'(1);
      img_w_q <= DIM_W'(1);
      ker_h_q <= K_W'(1);
      ker_w_q <= K_W'(1);
      pad_r_q <= '0;
      pad_c_q <= '0;
      str_r_q <= K_W'(1);
      str_c_q <= K_W'(1);
    end else if (cfg_we_i) begin
      unique case (iaw_pkg::cfg_reg_e'(cfg_index_i))
        iaw_pkg::CFG_IMAGE_HEIGHT:  img_h_q <= cfg_wdata_i[DIM_W-1:0];
        iaw_pkg::CFG_IMAGE_WIDTH:   img_w_q <= cfg_wdata_i[DIM_W-1:0];
        iaw_pkg::CFG_KERNEL_HEIGHT: ker_h_q <= cfg_wdata_i[K_W-1:0];
        iaw_pkg::CFG_KERNEL_WIDTH:  ker_w_q <= cfg_wdata_i[K_W-1:0];
        iaw_pkg::CFG_PAD_ROWS:      pad_r_q <= cfg_wdata_i[K_W-1:0];
        iaw_pkg::CFG_PAD_COLS:      pad_c_q <= cfg_wdata_i[K_W-1:0];
        iaw_pkg::CFG_STRIDE_ROWS:   str_r_q <= cfg_wdata_i[K_W-1:0];
        iaw_pkg::CFG_STRIDE_COLS:   str_c_q <= cfg_wdata_i[K_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions and strides; index 0 is rows, 1 is columns
  logic [1:0][DIM_W-1:0] dim;
  logic [1:0][K_W-1:0]   ker, pad, str;

  always_comb begin
    dim[0] = (img_h_q > DIM_W'(iaw_pkg::DIM_LIMIT)) ? DIM_W'(iaw_pkg::DIM_LIMIT) : img_h_q;
    dim[1] = (img_w_q > DIM_W'(iaw_pkg::DIM_LIMIT)) ? DIM_W'(iaw_pkg::DIM_LIMIT) : img_w_q;
    ker[0] = ker_h_q;
    ker[1] = ker_w_q;
    pad[0] = pad_r_q;
    pad[1] = pad_c_q;
    str[0] = (str_r_q == '0) ? K_W'(1) : str_r_q;
    str[1] = (str_c_q == '0) ? K_W'(1) : str_c_q;
  end

  // Output size setup: span = padded - extent, then span / stride bit by bit
  logic [1:0][SZ_W-1:0]  padded, extent;
  logic [1:0]            empty;
  logic [1:0][OUT_W-1:0] span;

  logic [1:0][OUT_W-1:0] quo_q, quo_nx, size_nx;
  logic [1:0][K_W-1:0]   rem_q, rem_nx;
  logic [1:0]            empty_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;

  always_comb begin
    logic [K_W:0] rem_sh;
    logic         ge;
    for (int d = 0; d < 2; d++) begin
      padded[d] = SZ_W'(dim[d]) + SZ_W'({pad[d], 1'b0});
      extent[d] = SZ_W'(((d == 0) ? iaw_pkg::ROW_DILATION : iaw_pkg::COL_DILATION)
                        * (int'(ker[d]) - 1) + 1);
      empty[d]  = (ker[d] == '0) || (extent[d] > padded[d]);
      span[d]   = OUT_W'(padded[d] - extent[d]);

      rem_sh     = {rem_q[d], quo_q[d][OUT_W-1]};
      ge         = rem_sh >= {1'b0, str[d]};
      rem_nx[d]  = ge ? K_W'(rem_sh - {1'b0, str[d]}) : rem_sh[K_W-1:0];
      quo_nx[d]  = {quo_q[d][OUT_W-2:0], ge};
      size_nx[d] = empty_q[d] ? '0 : quo_nx[d] + OUT_W'(1);
    end
  end

  // Walk state
  logic              walk_active_q;
  logic [CH_W-1:0]   chan_tot_q, chan_q;
  logic [OUT_W-1:0]  out_rows_q, out_cols_q, orow_q, ocol_q;
  logic [K_W-1:0]    krow_q, kcol_q;
  logic [ADDR_W-1:0] chan_base_q;

  // Row/column stage registers
  logic [DIM_W-1:0] row_q, col_q;
  logic             inside_q;
  logic [HW_W-1:0]  hw_q;

  logic [POS_W-1:0] pos_r, pos_c;
  logic             in_r, in_c;

  assign pos_r = POS_W'(orow_q) * POS_W'(str[0]) + POS_W'(krow_q) * POS_W'(iaw_pkg::ROW_DILATION);
  assign pos_c = POS_W'(ocol_q) * POS_W'(str[1]) + POS_W'(kcol_q) * POS_W'(iaw_pkg::COL_DILATION);
  assign in_r  = (pos_r >= POS_W'(pad[0])) && ((pos_r - POS_W'(pad[0])) < POS_W'(dim[0]));
  assign in_c  = (pos_c >= POS_W'(pad[1])) && ((pos_c - POS_W'(pad[1])) < POS_W'(dim[1]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      row_q    <= DIM_W'(pos_r - POS_W'(pad[0]));
      col_q    <= DIM_W'(pos_c - POS_W'(pad[1]));
      inside_q <= in_r && in_c;
      hw_q     <= HW_W'(dim[0]) * HW_W'(dim[1]);
    end
  end

  // Address and wrap flags for the advance cycle
  logic [ADDR_W-1:0] addr;
  logic              wrap_oc, wrap_or, wrap_kc, wrap_kr, wrap_ch;

  assign addr = inside_q ? chan_base_q + ADDR_W'(HW_W'(row_q) * HW_W'(dim[1])) + ADDR_W'(col_q)
                         : '0;
  assign wrap_oc = ({1'b0, ocol_q} + 1'b1) >= {1'b0, out_cols_q};
  assign wrap_or = ({1'b0, orow_q} + 1'b1) >= {1'b0, out_rows_q};
  assign wrap_kc = ({1'b0, kcol_q} + 1'b1) >= {1'b0, ker[1]};
  assign wrap_kr = ({1'b0, krow_q} + 1'b1) >= {1'b0, ker[0]};
  assign wrap_ch = ({1'b0, chan_q} + 1'b1) >= {1'b0, chan_tot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_active_q <= 1'b0;
      chan_tot_q    <= '0;
      out_rows_q    <= '0;
      out_cols_q    <= '0;
      chan_q        <= '0;
      krow_q        <= '0;
      kcol_q        <= '0;
      orow_q        <= '0;
      ocol_q        <= '0;
      chan_base_q   <= '0;
      quo_q         <= '0;
      rem_q         <= '0;
      empty_q       <= '0;
      div_cnt_q     <= '0;
    end else if (cmd_i.start) begin
      chan_tot_q    <= (in_data_i.channel_count > CH_W'(iaw_pkg::CH_LIMIT)) ?
                       CH_W'(iaw_pkg::CH_LIMIT) : in_data_i.channel_count;
      walk_active_q <= 1'b0;
      chan_q        <= '0;
      krow_q        <= '0;
      kcol_q        <= '0;
      orow_q        <= '0;
      ocol_q        <= '0;
      chan_base_q   <= '0;
      quo_q         <= span;
      rem_q         <= '0;
      empty_q       <= empty;
      div_cnt_q     <= DIV_CNT_W'(OUT_W - 1);
    end else if (cmd_i.div_step) begin
      quo_q     <= quo_nx;
      rem_q     <= rem_nx;
      div_cnt_q <= div_cnt_q - 1'b1;
      if (div_cnt_q == '0) begin
        out_rows_q    <= size_nx[0];
        out_cols_q    <= size_nx[1];
        walk_active_q <= (chan_tot_q != '0) && !empty_q[0] && !empty_q[1];
      end
    end else if (cmd_i.advance) begin
      // Advance the nest: output column fastest, channel slowest
      if (!wrap_oc) begin
        ocol_q <= ocol_q + 1'b1;
      end else begin
        ocol_q <= '0;
        if (!wrap_or) begin
          orow_q <= orow_q + 1'b1;
        end else begin
          orow_q <= '0;
          if (!wrap_kc) begin
            kcol_q <= kcol_q + 1'b1;
          end else begin
            kcol_q <= '0;
            if (!wrap_kr) begin
              krow_q <= krow_q + 1'b1;
            end else begin
              krow_q <= '0;
              if (!wrap_ch) begin
                chan_q      <= chan_q + 1'b1;
                chan_base_q <= chan_base_q + ADDR_W'(hw_q);
              end else begin
                chan_q        <= '0;
                chan_base_q   <= '0;
                walk_active_q <= 1'b0;
              end
            end
          end
        end
      end
    end
  end

  // Result register
  iaw_pkg::iaw_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      out_q.src_addr <= addr;
      out_q.is_pad   <= !inside_q;
      out_q.last     <= wrap_oc && wrap_or && wrap_kc && wrap_kr && wrap_ch;
    end
  end

  assign out_data_o           = out_q;
  assign status_o.div_last    = (div_cnt_q == '0);
  assign status_o.walk_active = walk_active_q;

endmodule

FILE: rtl/iaw_ctrl.sv
module iaw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_req_type_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  iaw_pkg::iaw_status_t status_i,
  output iaw_pkg::iaw_cmd_t    cmd_o
);

  iaw_pkg::iaw_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iaw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      iaw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_type_i == iaw_pkg::REQ_START) begin
            cmd_o.start = 1'b1;
            state_d     = iaw_pkg::ST_DIV;
          end else if (status_i.walk_active) begin
            cmd_o.calc = 1'b1;
            state_d    = iaw_pkg::ST_ADDR;
          end
        end
      end
      iaw_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = iaw_pkg::ST_IDLE;
        end
      end
      iaw_pkg::ST_ADDR: begin
        // hold until the result register is free or drains this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.advance = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = iaw_pkg::ST_IDLE;
        end
      end
      default: state_d = iaw_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != iaw_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: verif/tb_im2col_address_walk_unit.sv
`timescale 1ns / 1ps

module tb_im2col_address_walk_unit;
  import iaw_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 40;    // covers the start-time division
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int unsigned WALK_TARGET    = 820;   // directed part plus about 800 random items

  // Tracks the walk state and queues the column elements the block owes.
  class addr_walk_tracker;
    logic [CFG_W-1:0]  img_h, img_w;
    logic [K_W-1:0]    k_h, k_w, pad_r, pad_c, str_r, str_c;
    bit                active;
    int unsigned       n_chan, o_rows, o_cols;
    int unsigned       ch_i, kr_i, kc_i, or_i, oc_i;
    logic [ADDR_W-1:0] ch_base;
    iaw_out_t          pending_elems[$];
    int unsigned       errors;

    function new();
      img_h = 1; img_w = 1; k_h = 1; k_w = 1;
      pad_r = 0; pad_c = 0; str_r = 1; str_c = 1;
      active = 1'b0;
      n_chan = 0; o_rows = 0; o_cols = 0;
      ch_i = 0; kr_i = 0; kc_i = 0; or_i = 0; oc_i = 0;
      ch_base = '0;
      errors = 0;
    endfunction

    static function int unsigned fit_dim(int unsigned v);
      return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    static function int unsigned step_of(logic [K_W-1:0] s);
      return (s == 0) ? 1 : int'(s);
    endfunction

    static function int unsigned out_len(int unsigned img, int unsigned pad, int unsigned k,
                                         int unsigned dil, int unsigned stride);
      longint padded, extent;
      padded = longint'(img) + 2 * longint'(pad);
      if (k == 0) return 0;
      extent = longint'(dil) * (longint'(k) - 1) + 1;
      if (extent > padded) return 0;
      return int'((padded - extent) / longint'(stride) + 1);
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_IMAGE_HEIGHT:  img_h = val;
        CFG_IMAGE_WIDTH:   img_w = val;
        CFG_KERNEL_HEIGHT: k_h   = val[K_W-1:0];
        CFG_KERNEL_WIDTH:  k_w   = val[K_W-1:0];
        CFG_PAD_ROWS:      pad_r = val[K_W-1:0];
        CFG_PAD_COLS:      pad_c = val[K_W-1:0];
        CFG_STRIDE_ROWS:   str_r = val[K_W-1:0];
        CFG_STRIDE_COLS:   str_c = val[K_W-1:0];
        default: ;
      endcase
    endfunction

    // Elements in the walk just started; zero when the walk is empty.
    function longint walk_len();
      if (!active) return 0;
      return longint'(n_chan) * longint'(k_h) * longint'(k_w)
           * longint'(o_rows) * longint'(o_cols);
    endfunction

    // Returns 1 when the request does something (a start, or a next on a live walk).
    function bit note_request(iaw_in_t req);
      int unsigned h, w, ch;
      longint      row, col, addr;
      bit          in_img, at_end;
      iaw_out_t    elem;
      h = fit_dim(img_h);
      w = fit_dim(img_w);
      if (req.req_type == REQ_START) begin
        ch = req.channel_count;
        if (ch > MAX_CHANNELS) ch = MAX_CHANNELS;
        n_chan = ch;
        o_rows = out_len(h, pad_r, k_h, ROW_DILATION, step_of(str_r));
        o_cols = out_len(w, pad_c, k_w, COL_DILATION, step_of(str_c));
        ch_i = 0; kr_i = 0; kc_i = 0; or_i = 0; oc_i = 0;
        ch_base = '0;
        active = (ch != 0) && (o_rows != 0) && (o_cols != 0);
        return 1'b1;
      end
      if (!active) return 1'b0;

      row = longint'(or_i) * longint'(step_of(str_r)) - longint'(pad_r)
          + longint'(kr_i) * longint'(ROW_DILATION);
      col = longint'(oc_i) * longint'(step_of(str_c)) - longint'(pad_c)
          + longint'(kc_i) * longint'(COL_DILATION);
      in_img = (row >= 0) && (row < longint'(h)) && (col >= 0) && (col < longint'(w));
      addr = longint'(ch_base) + row * longint'(w) + col;

      at_end = 1'b0;
      if (oc_i + 1 >= o_cols) begin
        oc_i = 0;
        if (or_i + 1 >= o_rows) begin
          or_i = 0;
          if (kc_i + 1 >= k_w) begin
            kc_i = 0;
            if (kr_i + 1 >= k_h) begin
              kr_i = 0;
              if (ch_i + 1 >= n_chan) begin
                ch_i    = 0;
                ch_base = '0;
                at_end  = 1'b1;
              end else begin
                ch_i++;
                ch_base = ch_base + ADDR_W'(longint'(h) * longint'(w));
              end
            end else begin
              kr_i++;
            end
          end else begin
            kc_i++;
          end
        end else begin
          or_i++;
        end
      end else begin
        oc_i++;
      end
      if (at_end) active = 1'b0;

      elem.src_addr = in_img ? addr[ADDR_W-1:0] : '0;
      elem.is_pad   = !in_img;
      elem.last     = at_end;
      pending_elems.push_back(elem);
      return 1'b1;
    endfunction

    function void check_element(iaw_out_t got);
      iaw_out_t want;
      if (pending_elems.size() == 0) begin
        $error("result with no element pending: src_addr %0d is_pad %0b last %0b",
               got.src_addr, got.is_pad, got.last);
        errors++;
        return;
      end
      want = pending_elems.pop_front();
      if (got.src_addr !== want.src_addr) begin
        $error("src_addr: expected %0d, actual %0d", want.src_addr, got.src_addr);
        errors++;
      end
      if (got.is_pad !== want.is_pad) begin
        $error("is_pad: expected %0b, actual %0b", want.is_pad, got.is_pad);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  iaw_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  iaw_out_t             out_data;

  addr_walk_tracker tracker = new();

  // Handshake samples taken at the falling edge, acted on at the next rising edge.
  bit          in_take, out_take;
  iaw_out_t    out_snap;
  int unsigned quiet_cycles;
  int unsigned requests_sent;
  int unsigned walk_items;
  int unsigned send_pct = 26;
  int unsigned recv_pct = 62;

  im2col_address_walk_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #10 clk = ~clk;

  // Inputs only move at rising edges, so the falling edge sees what the next
  // rising edge will act on.
  always @(negedge clk) begin
    in_take  = rst_n && in_valid && (in_stall === 1'b0);
    out_take = rst_n && (out_valid === 1'b1) && !out_stall;
    out_snap = out_data;
  end

  // Check every result transfer; bail out when both channels go quiet too long.
  always @(posedge clk) begin
    if (out_take) tracker.check_element(out_snap);
    if (in_take || out_take || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver back-pressure; the rate follows the current idling phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  // Offer one request and hold it until the block takes it. Leave valid high:
  // the next call or drain_walk decides what it does in this step.
  task automatic send_req(input req_e kind, input int unsigned ch);
    iaw_in_t item;
    item.req_type      = kind;
    item.channel_count = ch[CH_W-1:0];
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_take);
    walk_items += tracker.note_request(item);
    requests_sent++;
    // Swap the idling sides after a third of the run, then drop idling entirely.
    if (requests_sent == 300) begin
      send_pct = 62;
      recv_pct = 26;
    end else if (requests_sent == 600) begin
      send_pct = 0;
      recv_pct = 0;
    end
  endtask

  // Drop valid, wait for every owed element, then let the block settle.
  task automatic drain_walk();
    in_valid <= 1'b0;
    while (tracker.pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers back to back; call only while the block is idle.
  task automatic apply_setting(input int unsigned h, input int unsigned w,
                               input int unsigned kh, input int unsigned kw,
                               input int unsigned pr, input int unsigned pc,
                               input int unsigned sr, input int unsigned sc);
    logic [CFG_W-1:0] vals [8];
    cfg_reg_e         idx;
    vals[CFG_IMAGE_HEIGHT]  = h[CFG_W-1:0];
    vals[CFG_IMAGE_WIDTH]   = w[CFG_W-1:0];
    vals[CFG_KERNEL_HEIGHT] = kh[CFG_W-1:0];
    vals[CFG_KERNEL_WIDTH]  = kw[CFG_W-1:0];
    vals[CFG_PAD_ROWS]      = pr[CFG_W-1:0];
    vals[CFG_PAD_COLS]      = pc[CFG_W-1:0];
    vals[CFG_STRIDE_ROWS]   = sr[CFG_W-1:0];
    vals[CFG_STRIDE_COLS]   = sc[CFG_W-1:0];
    for (int r = 0; r < 8; r++) begin
      idx = cfg_reg_e'(r);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[idx];
      @(posedge clk);
      tracker.write_reg(idx, vals[idx]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_nexts(input int unsigned n);
    repeat (n) send_req(REQ_NEXT, $urandom_range(2047, 0));
  endtask

  initial begin
    int unsigned h, w, kh, kw, pr, pc, sr, sc, ch, n;
    longint      len;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults, 1x1 everything: next while idle, empty walk on zero
    // channels, then a one-element walk and a next after it has ended.
    send_req(REQ_NEXT, 0);
    send_req(REQ_START, 0);
    send_req(REQ_NEXT, 5);
    send_req(REQ_START, 1);
    send_nexts(2);
    drain_walk();

    // Padding on both axes with unequal strides.
    apply_setting(5, 7, 3, 2, 1, 2, 2, 1);
    send_req(REQ_START, 2);
    send_nexts(5);
    drain_walk();

    // Widest image, largest kernel, padding and stride; channel count over the
    // limit saturates. Restart the walk mid-way.
    apply_setting(1024, 1024, 15, 15, 15, 15, 15, 15);
    send_req(REQ_START, 2047);
    send_nexts(2);
    send_req(REQ_START, 1024);
    send_nexts(1);
    drain_walk();

    // Oversized image dimensions saturate; zero stride counts as one.
    apply_setting(2047, 1500, 1, 1, 0, 0, 0, 0);
    send_req(REQ_START, 3);
    send_nexts(2);
    drain_walk();

    // Zero-sized image: every element is padding.
    apply_setting(0, 0, 2, 3, 1, 2, 1, 1);
    send_req(REQ_START, 1);
    send_nexts(2);
    drain_walk();

    // Zero kernel height: empty walk, nexts are ignored.
    apply_setting(4, 4, 0, 2, 0, 0, 1, 1);
    send_req(REQ_START, 1);
    send_nexts(1);
    drain_walk();

    // Random settings, each followed by a handful of walks. Most walks run to
    // their last element; the rest are cut short by the next start.
    while (walk_items < WALK_TARGET) begin
      if ($urandom_range(7) == 0) begin
        h  = $urandom_range(1) ? 1024 : $urandom_range(1024, 1);
        w  = $urandom_range(1) ? 1024 : $urandom_range(1024, 1);
        kh = $urandom_range(15, 1);
        kw = $urandom_range(15, 1);
        pr = $urandom_range(15, 0);
        pc = $urandom_range(15, 0);
        sr = $urandom_range(15, 1);
        sc = $urandom_range(15, 1);
      end else begin
        h  = $urandom_range(6, 1);
        w  = $urandom_range(6, 1);
        kh = $urandom_range(9) == 0 ? $urandom_range(15, 1) : $urandom_range(3, 1);
        kw = $urandom_range(9) == 0 ? $urandom_range(15, 1) : $urandom_range(3, 1);
        pr = $urandom_range(2, 0);
        pc = $urandom_range(2, 0);
        sr = $urandom_range(3, 1);
        sc = $urandom_range(3, 1);
      end
      apply_setting(h, w, kh, kw, pr, pc, sr, sc);

      repeat ($urandom_range(6, 3)) begin
        n = $urandom_range(9);
        if (n < 7)       ch = $urandom_range(3, 1);
        else if (n == 7) ch = 0;
        else             ch = $urandom_range(2047, 0);
        send_req(REQ_START, ch);
        len = tracker.walk_len();
        if (len == 0)
          n = $urandom_range(3, 0);
        else if (len <= 120 && $urandom_range(9) < 8)
          n = int'(len) + $urandom_range(2, 0);
        else
          n = $urandom_range(40, 1);
        send_nexts(n);
      end
      drain_walk();
    end

    if (tracker.errors == 0 && tracker.pending_elems.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
